>>> src/nlp_pkg.sv
package nlp_pkg;

   localparam int MAX_LEN = 16;
   localparam int ELEM_W  = 16;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ELEM_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } mem_req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] rd_data_a;
      logic [ELEM_W-1:0] rd_data_b;
   } mem_rsp_type;

endpackage

>>> src/nlp_req_if.sv
interface nlp_req_if;
   logic                       valid;
   logic                       ready;
   logic [nlp_pkg::ELEM_W-1:0] element;
   logic                       is_last;

   modport source (output valid, output element, output is_last, input ready);
   modport sink   (input valid, input element, input is_last, output ready);
endinterface

>>> src/nlp_rsp_if.sv
interface nlp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [nlp_pkg::ELEM_W-1:0] out_element;
   logic                       out_last;
   logic                       has_next;
   logic                       overflow;

   modport source (output valid, output out_element, output out_last, output has_next,
                   output overflow, input ready);
   modport sink   (input valid, input out_element, input out_last, input has_next,
                   input overflow, output ready);
endinterface

>>> src/nlp_seq_mem.sv
module nlp_seq_mem (
   input  logic                 clock,
   input  nlp_pkg::mem_req_type mem_req,
   output nlp_pkg::mem_rsp_type mem_rsp
);

   logic [nlp_pkg::ELEM_W-1:0] mem [nlp_pkg::MAX_LEN];
   logic [nlp_pkg::ELEM_W-1:0] rd_a_ff;
   logic [nlp_pkg::ELEM_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_a_ff <= mem[mem_req.rd_addr_a];
         rd_b_ff <= mem[mem_req.rd_addr_b];
      end
   end

   assign mem_rsp.rd_data_a = rd_a_ff;
   assign mem_rsp.rd_data_b = rd_b_ff;

endmodule

>>> src/next_lexicographic_permutation_core.sv
// next lexicographic permutation of a sequence of 16-bit unsigned values
// req channel: one element per transfer, is_last marks the final one; the
// sequence is stored in a 16-entry buffer, extra elements are dropped and
// reported through overflow on every result of that sequence
// rsp channel: after the last element the block rearranges the buffer and
// returns the sequence one element per transfer, out_last on the final one,
// has_next cleared when no next permutation exists (sequence left as is)
// loading accepts one element per cycle; processing n elements then runs
// pivot steps, successor steps, swapped pairs and returned elements,
// all through one buffer port pair and one shared comparator
// req_ready is low from the last element until the final result transfer
// a stalled receiver holds the current result; nothing is lost or repeated
// reset (synchronous) empties the buffer count and clears all flags
module next_lexicographic_permutation_core (
   input logic       clock,
   input logic       reset,
   nlp_req_if.sink   req_chan,
   nlp_rsp_if.source rsp_chan
);

   typedef enum logic [9:0] {
      S_LOAD = 10'b0000000001,
      S_PRD  = 10'b0000000010,
      S_PCMP = 10'b0000000100,
      S_SRD  = 10'b0000001000,
      S_SCMP = 10'b0000010000,
      S_SW1  = 10'b0000100000,
      S_SW2  = 10'b0001000000,
      S_SWRD = 10'b0010000000,
      S_ORD  = 10'b0100000000,
      S_OUT  = 10'b1000000000
   } state_type;

   localparam logic [nlp_pkg::CNT_W-1:0] FULL = nlp_pkg::CNT_W'(nlp_pkg::MAX_LEN);

   state_type                     state_ff, state_in;
   logic [nlp_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          ovf_ff, ovf_in;
   logic                          more_ff, more_in;
   logic                          rev_ff, rev_in;
   logic [nlp_pkg::ADDR_W-1:0]    a_ff, a_in;
   logic [nlp_pkg::ADDR_W-1:0]    b_ff, b_in;

   nlp_pkg::mem_req_type          mem_req;
   nlp_pkg::mem_rsp_type          mem_rsp;

   logic                          req_xfer;
   logic                          rsp_xfer;
   logic                          room;
   logic [nlp_pkg::CNT_W-1:0]     n_new;
   logic [nlp_pkg::ADDR_W-1:0]    last_idx;
   logic                          less;

   nlp_seq_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   assign req_chan.ready = (state_ff == S_LOAD);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (state_ff == S_OUT);
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;

   assign room     = (count_ff < FULL);
   assign n_new    = room ? count_ff + 1'b1 : count_ff;
   assign last_idx = nlp_pkg::ADDR_W'(count_ff - 1'b1);
   assign less     = (mem_rsp.rd_data_a < mem_rsp.rd_data_b);

   assign rsp_chan.out_element = mem_rsp.rd_data_a;
   assign rsp_chan.out_last    = (a_ff == last_idx);
   assign rsp_chan.has_next    = more_ff;
   assign rsp_chan.overflow    = ovf_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      more_in  = more_ff;
      rev_in   = rev_ff;
      a_in     = a_ff;
      b_in     = b_ff;

      mem_req           = '0;
      mem_req.rd_addr_a = a_ff;
      mem_req.rd_addr_b = b_ff;

      unique case (state_ff)
         S_LOAD: begin
            mem_req.wr_addr = nlp_pkg::ADDR_W'(count_ff);
            mem_req.wr_data = req_chan.element;
            if (req_xfer) begin
               mem_req.wr_en = room;
               count_in      = n_new;
               if (!room) begin
                  ovf_in = 1'b1;
               end
               if (req_chan.is_last) begin
                  if (n_new < nlp_pkg::CNT_W'(2)) begin
                     a_in     = '0;
                     state_in = S_ORD;
                  end else begin
                     b_in     = nlp_pkg::ADDR_W'(n_new - 1'b1);
                     a_in     = nlp_pkg::ADDR_W'(n_new - 2'd2);
                     state_in = S_PRD;
                  end
               end
            end
         end
         // pivot search from the right
         S_PRD: begin
            mem_req.rd_en = 1'b1;
            state_in      = S_PCMP;
         end
         S_PCMP: begin
            if (less) begin
               more_in  = 1'b1;
               b_in     = last_idx;
               state_in = S_SRD;
            end else if (a_ff == '0) begin
               state_in = S_ORD;
            end else begin
               a_in     = a_ff - 1'b1;
               b_in     = b_ff - 1'b1;
               state_in = S_PRD;
            end
         end
         // rightmost element larger than the pivot
         S_SRD: begin
            mem_req.rd_en = 1'b1;
            state_in      = S_SCMP;
         end
         S_SCMP: begin
            rev_in = 1'b0;
            if (less) begin
               state_in = S_SW1;
            end else begin
               b_in     = b_ff - 1'b1;
               state_in = S_SRD;
            end
         end
         S_SWRD: begin
            mem_req.rd_en = 1'b1;
            state_in      = S_SW1;
         end
         S_SW1: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = a_ff;
            mem_req.wr_data = mem_rsp.rd_data_b;
            state_in        = S_SW2;
         end
         S_SW2: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = b_ff;
            mem_req.wr_data = mem_rsp.rd_data_a;
            rev_in          = 1'b1;
            a_in            = a_ff + 1'b1;
            b_in            = rev_ff ? b_ff - 1'b1 : last_idx;
            if ((a_ff + 1'b1) < (rev_ff ? b_ff - 1'b1 : last_idx)) begin
               state_in = S_SWRD;
            end else begin
               a_in     = '0;
               state_in = S_ORD;
            end
         end
         // result readout
         S_ORD: begin
            mem_req.rd_en = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (rsp_xfer) begin
               if (a_ff == last_idx) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  more_in  = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  a_in     = a_ff + 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         more_ff  <= 1'b0;
         rev_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         more_ff  <= more_in;
         rev_ff   <= rev_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule
